>>> rtl/core/retransmit_table_with_send_queue_top_assert.svh
// Assertion macros for the retransmit table core.
// No dependencies; included by the top level, which supplies clk_i and rst_ni.
`ifndef RETRANSMIT_TABLE_WITH_SEND_QUEUE_TOP_ASSERT_SVH
`define RETRANSMIT_TABLE_WITH_SEND_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Checked property, sampled on clk_i, off while reset is asserted
`define RTQ_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rtq assertion failed");
// Checked property that also holds during reset
`define RTQ_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("rtq assertion failed");
`else
`define RTQ_ASSERT(name, prop)
`define RTQ_ASSERT_ALWAYS(name, prop)
`endif

`endif

>>> rtl/core/rtq_pkg.sv
// Package for the retransmit table core: sizes, codes and word types.
// No dependencies; used by retransmit_table_with_send_queue_top.
package rtq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW = QAW + 1;
  localparam int unsigned TAW = $clog2(TABLE_DEPTH);

  localparam logic [15:0] TIMEOUT_RESET = 16'd2;

  // input kinds
  localparam logic [1:0] KIND_SUBMIT = 2'd0;
  localparam logic [1:0] KIND_ACK    = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // result event codes
  localparam logic [2:0] EV_ACCEPTED   = 3'd0;
  localparam logic [2:0] EV_REJECTED   = 3'd1;
  localparam logic [2:0] EV_ACK_HIT    = 3'd2;
  localparam logic [2:0] EV_ACK_MISS   = 3'd3;
  localparam logic [2:0] EV_TRANSMIT   = 3'd4;
  localparam logic [2:0] EV_RETRANSMIT = 3'd5;
  localparam logic [2:0] EV_TICK_DONE  = 3'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] msg_handle;
    logic [15:0] ack_seq;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] out_seq;
    logic [15:0] out_handle;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] seq;
  } fifo_ent_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] handle;
    logic [15:0] stamp;
  } tbl_ent_t;

endpackage

>>> rtl/core/retransmit_table_with_send_queue_top.sv
// Retransmit table with send queue: sender side of a reliable link.
// Depends on rtq_pkg and retransmit_table_with_send_queue_top_assert.svh.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------
//  in      | input     | in_valid_i / in_ready_o    | in_word_i  (in_word_t)
//  out     | output    | out_valid_o / out_ready_i  | out_word_o (out_word_t)
//  cfg     | input     | cfg_we_i, no wait          | cfg_wdata_i (timeout)
//
// A submit is answered from idle. An ack walks the table slot by slot (read,
// then compare). A tick walks the slots the same way on the timeout scan, then
// a fill pass visits slots in turn and emits one queue word into each free slot,
// then the done word follows. The single-port table memory with its registered
// read sets this pacing.
// Reset clears control state and all table valid bits at once; no sweep.
// Any result word waits in the output register while out_ready_i is low.

`include "retransmit_table_with_send_queue_top_assert.svh"

module retransmit_table_with_send_queue_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rtq_pkg::in_word_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rtq_pkg::out_word_t out_word_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_ACK_RD  = 8'b0000_0010,
    ST_ACK_EV  = 8'b0000_0100,
    ST_RT_RD   = 8'b0000_1000,
    ST_RT_EV   = 8'b0001_0000,
    ST_TX_SCAN = 8'b0010_0000,
    ST_TX_EMIT = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] timeout_q;
  logic [15:0] now_q, now_d;
  logic [15:0] next_seq_q, next_seq_d;
  logic [15:0] ack_seq_q, ack_seq_d;
  logic [rtq_pkg::QAW-1:0] head_q, head_d;
  logic [rtq_pkg::QCW-1:0] count_q, count_d;
  logic [rtq_pkg::TAW-1:0] idx_q, idx_d;
  logic [rtq_pkg::TABLE_DEPTH-1:0] vld_q, vld_d;

  // memories and their registered read data
  rtq_pkg::fifo_ent_t fifo_mem [rtq_pkg::QUEUE_DEPTH];
  rtq_pkg::tbl_ent_t  tbl_mem  [rtq_pkg::TABLE_DEPTH];
  rtq_pkg::fifo_ent_t fifo_rd_q;
  rtq_pkg::tbl_ent_t  tbl_rd_q;

  logic               fifo_we;
  logic [rtq_pkg::QAW-1:0] fifo_waddr;
  rtq_pkg::fifo_ent_t fifo_wdata;
  logic               tbl_we;
  rtq_pkg::tbl_ent_t  tbl_wdata;

  // output register
  logic               out_valid_q;
  rtq_pkg::out_word_t out_q, out_d;
  logic               out_load;
  logic               out_free;

  logic               in_fire;
  logic               idx_last;
  logic               fifo_full;
  logic [15:0]        age;
  logic [rtq_pkg::QCW-1:0] tail_sum;
  logic [rtq_pkg::QCW-1:0] tail_wrap;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign idx_last  = (idx_q == rtq_pkg::TAW'(rtq_pkg::TABLE_DEPTH - 1));
  assign fifo_full = (count_q == rtq_pkg::QCW'(rtq_pkg::QUEUE_DEPTH));
  assign age       = now_q - tbl_rd_q.stamp;

  // tail slot of the queue, wrapped once
  assign tail_sum  = {1'b0, head_q} + count_q;
  assign tail_wrap = (tail_sum >= rtq_pkg::QCW'(rtq_pkg::QUEUE_DEPTH)) ?
                     tail_sum - rtq_pkg::QCW'(rtq_pkg::QUEUE_DEPTH) : tail_sum;

  // sequencer
  always_comb begin
    state_d    = state_q;
    now_d      = now_q;
    next_seq_d = next_seq_q;
    ack_seq_d  = ack_seq_q;
    head_d     = head_q;
    count_d    = count_q;
    idx_d      = idx_q;
    vld_d      = vld_q;
    out_load   = 1'b0;
    out_d      = out_q;
    fifo_we    = 1'b0;
    fifo_waddr = tail_wrap[rtq_pkg::QAW-1:0];
    fifo_wdata = '{handle: in_word_i.msg_handle, seq: next_seq_q};
    tbl_we     = 1'b0;
    tbl_wdata  = '{seq: tbl_rd_q.seq, handle: tbl_rd_q.handle, stamp: now_q};

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_word_i.kind)
            rtq_pkg::KIND_SUBMIT: begin
              out_load = 1'b1;
              if (fifo_full) begin
                out_d = '{event_res: rtq_pkg::EV_REJECTED, out_seq: 16'd0,
                          out_handle: 16'd0, last: 1'b1};
              end else begin
                fifo_we    = 1'b1;
                count_d    = count_q + rtq_pkg::QCW'(1);
                next_seq_d = next_seq_q + 16'd1;
                out_d = '{event_res: rtq_pkg::EV_ACCEPTED, out_seq: next_seq_q,
                          out_handle: 16'd0, last: 1'b1};
              end
            end
            rtq_pkg::KIND_ACK: begin
              ack_seq_d = in_word_i.ack_seq;
              idx_d     = '0;
              state_d   = ST_ACK_RD;
            end
            rtq_pkg::KIND_TICK: begin
              now_d   = now_q + 16'd1;
              idx_d   = '0;
              state_d = ST_RT_RD;
            end
            default: ;  // unknown kind: dropped without a result
          endcase
        end
      end

      ST_ACK_RD: state_d = ST_ACK_EV;

      // first valid slot with a matching number wins
      ST_ACK_EV: begin
        if (vld_q[idx_q] && (tbl_rd_q.seq == ack_seq_q)) begin
          if (out_free) begin
            vld_d[idx_q] = 1'b0;
            out_load = 1'b1;
            out_d = '{event_res: rtq_pkg::EV_ACK_HIT, out_seq: ack_seq_q,
                      out_handle: 16'd0, last: 1'b1};
            state_d = ST_IDLE;
          end
        end else if (idx_last) begin
          if (out_free) begin
            out_load = 1'b1;
            out_d = '{event_res: rtq_pkg::EV_ACK_MISS, out_seq: ack_seq_q,
                      out_handle: 16'd0, last: 1'b1};
            state_d = ST_IDLE;
          end
        end else begin
          idx_d   = idx_q + rtq_pkg::TAW'(1);
          state_d = ST_ACK_RD;
        end
      end

      ST_RT_RD: state_d = ST_RT_EV;

      // timeout scan: resend and restamp expired entries
      ST_RT_EV: begin
        if (vld_q[idx_q] && (age >= timeout_q)) begin
          if (out_free) begin
            out_load = 1'b1;
            out_d = '{event_res: rtq_pkg::EV_RETRANSMIT, out_seq: tbl_rd_q.seq,
                      out_handle: tbl_rd_q.handle, last: 1'b0};
            tbl_we  = 1'b1;
            idx_d   = idx_q + rtq_pkg::TAW'(1);
            state_d = idx_last ? ST_TX_SCAN : ST_RT_RD;
          end
        end else begin
          idx_d   = idx_q + rtq_pkg::TAW'(1);
          state_d = idx_last ? ST_TX_SCAN : ST_RT_RD;
        end
      end

      // fill pass: find the next free slot while the queue holds words;
      // the stay in this state also lets fifo_rd_q follow a moved head
      ST_TX_SCAN: begin
        if (count_q == '0) begin
          state_d = ST_DONE;
        end else if (!vld_q[idx_q]) begin
          state_d = ST_TX_EMIT;
        end else if (idx_last) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + rtq_pkg::TAW'(1);
        end
      end

      ST_TX_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d = '{event_res: rtq_pkg::EV_TRANSMIT, out_seq: fifo_rd_q.seq,
                    out_handle: fifo_rd_q.handle, last: 1'b0};
          tbl_we       = 1'b1;
          tbl_wdata    = '{seq: fifo_rd_q.seq, handle: fifo_rd_q.handle, stamp: now_q};
          vld_d[idx_q] = 1'b1;
          head_d  = (head_q == rtq_pkg::QAW'(rtq_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : head_q + rtq_pkg::QAW'(1);
          count_d = count_q - rtq_pkg::QCW'(1);
          idx_d   = idx_q + rtq_pkg::TAW'(1);
          state_d = idx_last ? ST_DONE : ST_TX_SCAN;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d = '{event_res: rtq_pkg::EV_TICK_DONE, out_seq: 16'd0,
                    out_handle: 16'd0, last: 1'b1};
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      timeout_q   <= rtq_pkg::TIMEOUT_RESET;
      now_q       <= '0;
      next_seq_q  <= '0;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      now_q      <= now_d;
      next_seq_q <= next_seq_d;
      head_q     <= head_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      vld_q      <= vld_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ack_seq_q <= ack_seq_d;
    out_q     <= out_d;
  end

  // queue memory: write at the tail, read at the head every cycle
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
    fifo_rd_q <= fifo_mem[head_q];
  end

  // table memory: read at the scan index every cycle; a write to a slot is
  // always followed by a fresh read cycle before that slot is looked at again
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[idx_q] <= tbl_wdata;
    end
    tbl_rd_q <= tbl_mem[idx_q];
  end

  // checks
  `RTQ_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o)
  `RTQ_ASSERT(a_count_bound, count_q <= rtq_pkg::QCW'(rtq_pkg::QUEUE_DEPTH))
  `RTQ_ASSERT(a_tbl_we_emits, tbl_we |-> out_load)
  `RTQ_ASSERT(a_reject_keeps_seq, (in_fire && (in_word_i.kind == rtq_pkg::KIND_SUBMIT) && fifo_full) |=> $stable(next_seq_q))
  `RTQ_ASSERT(a_tx_pops, (state_q == ST_TX_EMIT && out_free) |=> (count_q == $past(count_q) - rtq_pkg::QCW'(1)))

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for retransmit_table_with_send_queue_top: directed and random
// submit / ack / tick traffic, checked word by word against a built-in predictor.
// Depends on rtq_pkg and the top level of the retransmit table core.

module tb_top;

  localparam int unsigned DRAIN_CYCLES = 3 * rtq_pkg::TABLE_DEPTH + 32;
  localparam int unsigned RUN_LIMIT_NS = 10_000_000;
  localparam int unsigned PHASE_WORDS  = 37;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  rtq_pkg::in_word_t  in_word_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  rtq_pkg::out_word_t out_word_o;
  logic               cfg_we_i    = 1'b0;
  logic [15:0]        cfg_wdata_i = '0;

  // idling control for the sender and the result sink, and the mismatch count
  bit          no_idle     = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned mismatches  = 0;

  // predictor state
  logic [15:0]        timeout_cfg = rtq_pkg::TIMEOUT_RESET;
  rtq_pkg::fifo_ent_t queue_ent [rtq_pkg::QUEUE_DEPTH];
  int unsigned        queue_head  = 0;
  int unsigned        queue_count = 0;
  bit                 slot_busy [rtq_pkg::TABLE_DEPTH];
  rtq_pkg::tbl_ent_t  slot_ent  [rtq_pkg::TABLE_DEPTH];
  logic [15:0]        tick_now    = '0;
  logic [15:0]        seq_next    = '0;
  rtq_pkg::out_word_t awaited_events[$];

  retransmit_table_with_send_queue_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  function automatic rtq_pkg::in_word_t make_word(logic [1:0] k, logic [15:0] hnd,
                                                  logic [15:0] seq);
    rtq_pkg::in_word_t w;
    w.kind       = k;
    w.msg_handle = hnd;
    w.ack_seq    = seq;
    return w;
  endfunction

  function automatic void expect_word(logic [2:0] ev, logic [15:0] seq, logic [15:0] hnd,
                                      logic fin);
    rtq_pkg::out_word_t w;
    w.event_res  = ev;
    w.out_seq    = seq;
    w.out_handle = hnd;
    w.last       = fin;
    awaited_events.push_back(w);
  endfunction

  // Predict the result words of one accepted input word and update the shadow state
  function automatic void predict_events(rtq_pkg::in_word_t w);
    bit                 found;
    logic [15:0]        age;
    rtq_pkg::fifo_ent_t head_ent;
    found = 1'b0;
    case (w.kind)
      rtq_pkg::KIND_SUBMIT: begin
        if (queue_count >= rtq_pkg::QUEUE_DEPTH) begin
          expect_word(rtq_pkg::EV_REJECTED, '0, '0, 1'b1);
        end else begin
          queue_ent[(queue_head + queue_count) % rtq_pkg::QUEUE_DEPTH] =
            '{handle: w.msg_handle, seq: seq_next};
          queue_count++;
          expect_word(rtq_pkg::EV_ACCEPTED, seq_next, '0, 1'b1);
          seq_next++;
        end
      end
      rtq_pkg::KIND_ACK: begin
        // only the lowest matching slot is freed
        for (int i = 0; i < rtq_pkg::TABLE_DEPTH && !found; i++) begin
          if (slot_busy[i] && slot_ent[i].seq == w.ack_seq) begin
            slot_busy[i] = 1'b0;
            found = 1'b1;
          end
        end
        expect_word(found ? rtq_pkg::EV_ACK_HIT : rtq_pkg::EV_ACK_MISS, w.ack_seq, '0,
                    1'b1);
      end
      rtq_pkg::KIND_TICK: begin
        tick_now++;
        // timeout scan in slot order, restamp on retransmit
        for (int i = 0; i < rtq_pkg::TABLE_DEPTH; i++) begin
          if (slot_busy[i]) begin
            age = tick_now - slot_ent[i].stamp;
            if (age >= timeout_cfg) begin
              expect_word(rtq_pkg::EV_RETRANSMIT, slot_ent[i].seq, slot_ent[i].handle,
                          1'b0);
              slot_ent[i].stamp = tick_now;
            end
          end
        end
        // refill the lowest free slots from the send queue
        for (int i = 0; i < rtq_pkg::TABLE_DEPTH && queue_count > 0; i++) begin
          if (!slot_busy[i]) begin
            head_ent    = queue_ent[queue_head];
            queue_head  = (queue_head + 1) % rtq_pkg::QUEUE_DEPTH;
            queue_count--;
            slot_busy[i] = 1'b1;
            slot_ent[i]  = '{seq: head_ent.seq, handle: head_ent.handle, stamp: tick_now};
            expect_word(rtq_pkg::EV_TRANSMIT, head_ent.seq, head_ent.handle, 1'b0);
          end
        end
        expect_word(rtq_pkg::EV_TICK_DONE, '0, '0, 1'b1);
      end
      default: ;  // unused kind: no word, no state change
    endcase
  endfunction

  // Ack mostly an outstanding sequence number, sometimes a random one
  function automatic logic [15:0] pick_ack_seq();
    int busy_idx[$];
    for (int i = 0; i < rtq_pkg::TABLE_DEPTH; i++) begin
      if (slot_busy[i]) busy_idx.push_back(i);
    end
    if (busy_idx.size() > 0 && $urandom_range(0, 9) < 8) begin
      return slot_ent[busy_idx[$urandom_range(0, busy_idx.size() - 1)]].seq;
    end
    return 16'($urandom);
  endfunction

  // Send one input word; valid stays high afterwards until the next call or a pause
  task automatic push_word(rtq_pkg::in_word_t w);
    int unsigned gap;
    gap = (!no_idle && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predict_events(w);
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_events.size() != 0);
  endtask

  // Drained, plus slack for words that cause no result
  task automatic wait_idle();
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_timeout(logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    timeout_cfg = value;
  endtask

  // Fill the send queue, then one more submit must be rejected
  task automatic test_queue_full();
    logic [15:0] corner [4];
    logic [15:0] hnd;
    corner = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};
    for (int i = 0; i <= rtq_pkg::QUEUE_DEPTH; i++) begin
      hnd = (i < 4) ? corner[i] : 16'($urandom);
      push_word(make_word(rtq_pkg::KIND_SUBMIT, hnd, 16'($urandom)));
    end
  endtask

  // Full refill on one tick, then ack hit, repeated ack and far miss
  task automatic test_ack_lookup();
    push_word(make_word(rtq_pkg::KIND_TICK, 16'($urandom), 16'($urandom)));
    push_word(make_word(rtq_pkg::KIND_ACK, 16'($urandom), 16'h0000));
    push_word(make_word(rtq_pkg::KIND_ACK, 16'($urandom), 16'h0000));
    push_word(make_word(rtq_pkg::KIND_ACK, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_ignored_kind();
    push_word(make_word(KIND_UNUSED, 16'hFFFF, 16'hFFFF));
    wait_idle();
  endtask

  // Timeout zero retransmits everything; the maximum holds off everything
  task automatic test_timeout_extremes();
    set_timeout(16'h0000);
    push_word(make_word(rtq_pkg::KIND_SUBMIT, 16'h8001, 16'h7FFE));
    push_word(make_word(rtq_pkg::KIND_TICK, 16'($urandom), 16'($urandom)));
    wait_idle();
    set_timeout(16'hFFFF);
    push_word(make_word(rtq_pkg::KIND_TICK, 16'($urandom), 16'($urandom)));
  endtask

  // One random phase: mostly well-formed traffic, a few stray acks and unused kinds
  task automatic run_phase(logic [15:0] tmo, bit quiet);
    int unsigned counted;
    int unsigned roll;
    wait_idle();
    set_timeout(tmo);
    no_idle = quiet;
    counted = 0;
    while (counted < PHASE_WORDS) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        push_word(make_word(rtq_pkg::KIND_SUBMIT, 16'($urandom), 16'($urandom)));
      end else if (roll < 65) begin
        push_word(make_word(rtq_pkg::KIND_ACK, 16'($urandom), pick_ack_seq()));
      end else if (roll < 97) begin
        push_word(make_word(rtq_pkg::KIND_TICK, 16'($urandom), 16'($urandom)));
      end else begin
        push_word(make_word(KIND_UNUSED, 16'($urandom), 16'($urandom)));
        continue;
      end
      counted++;
      if ($urandom_range(0, 24) == 0) pause_until_drained();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_phase(16'd1, 1'b0);
    run_phase(16'd3, 1'b1);
    run_phase(16'($urandom_range(1, 6)), 1'b0);
    run_phase(rtq_pkg::TIMEOUT_RESET, 1'b0);
  endtask

  // Result sink with random back-pressure
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      stall_left  <= idle_len() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin : check_results
    rtq_pkg::out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_events.size() == 0) begin
        $error("unexpected result word %h", out_word_o);
        mismatches++;
      end else begin
        want = awaited_events.pop_front();
        if (out_word_o.event_res !== want.event_res) begin
          $error("event_res expected %0d got %0d", want.event_res, out_word_o.event_res);
          mismatches++;
        end
        if (out_word_o.out_seq !== want.out_seq) begin
          $error("out_seq expected %0d got %0d", want.out_seq, out_word_o.out_seq);
          mismatches++;
        end
        if (out_word_o.out_handle !== want.out_handle) begin
          $error("out_handle expected %0d got %0d", want.out_handle, out_word_o.out_handle);
          mismatches++;
        end
        if (out_word_o.last !== want.last) begin
          $error("last expected %0d got %0d", want.last, out_word_o.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_queue_full();
    test_ack_lookup();
    test_ignored_kind();
    test_timeout_extremes();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
